FILE: rtl/wnst_pkg.sv
// Package with shared constants, types and codes for the nearest-sample tracker.
`default_nettype none
package wnst_pkg;
  localparam int NUM_TRAJ = 8;
  localparam int MAX_SAMPLES = 1024;
  localparam int NUM_JOINTS = 6;
  localparam int TW = $clog2(NUM_TRAJ);
  localparam int SW = $clog2(MAX_SAMPLES);
  localparam int LW = $clog2(MAX_SAMPLES + 1);
  localparam int WW = 11;
  localparam int DW = 35;
  localparam int JW = 16;
  localparam int AW = TW + SW;
  localparam int QDEPTH = 2;
  localparam logic [WW-1:0] WINDOW_RESET = WW'(40);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_LEN   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef logic signed [JW-1:0] joint_t;
  typedef joint_t [NUM_JOINTS-1:0] jvec_t;

  typedef struct packed {
    op_t            op;
    logic [TW-1:0]  dataset;
    logic           ds_ok;
    logic [SW-1:0]  sample_index;
    logic [LW-1:0]  sample_count;
    jvec_t          joints;
  } cmd_t;

  typedef struct packed {
    logic [TW-1:0] dataset;
    logic [SW-1:0] best_index;
    logic [DW-1:0] best_dist;
    logic          empty;
    logic          last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/wnst_front.sv
// Front end: accepts input beats, decodes and checks them, and queues commands.
`default_nettype none
module wnst_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire wnst_pkg::op_t  op,
  input  wire logic [2:0]     dataset,
  input  wire logic [9:0]     sample_index,
  input  wire logic [10:0]    sample_count,
  input  wire wnst_pkg::jvec_t joints,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output wnst_pkg::cmd_t      cmd
);
  import wnst_pkg::*;

  cmd_t q [QDEPTH];
  logic wp, rp;
  logic [1:0] count;
  cmd_t in_cmd;
  logic push, pop;

  always_comb begin
    in_cmd.op = op;
    in_cmd.dataset = TW'(dataset);
    in_cmd.ds_ok = ({29'd0, dataset} < NUM_TRAJ);
    in_cmd.sample_index = SW'(sample_index);
    in_cmd.sample_count = (sample_count > 11'(MAX_SAMPLES)) ? LW'(MAX_SAMPLES) :
                          LW'(sample_count);
    in_cmd.joints = joints;
  end

  assign in_ready = (count != 2'(QDEPTH));
  assign push = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/wnst_back.sv
// Back end: sample store, length and tracked index tables, and the window search.
`default_nettype none
module wnst_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [10:0]    window_size,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire wnst_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_ready,
  output wnst_pkg::res_t      res
);
  import wnst_pkg::*;

  jvec_t mem [NUM_TRAJ*MAX_SAMPLES];
  jvec_t rd;
  logic [LW-1:0] tlen [NUM_TRAJ];
  logic [SW-1:0] tidx [NUM_TRAJ];

  state_t state, state_next;
  logic [TW-1:0] d;
  logic [LW-1:0] addr_i, end_i;
  logic [AW-1:0] raddr;
  jvec_t qv;
  logic p1, p2;
  logic [SW-1:0] i1, i2;
  logic [2*JW+1:0] sq [NUM_JOINTS];
  logic [DW-1:0] sum_sq;
  logic [DW-1:0] best_dist;
  logic [SW-1:0] best_idx;
  logic found;
  logic [LW:0] end_sum;
  logic issue;

  assign cmd_ready = (state == ST_IDLE);
  assign end_sum = {1'b0, LW'(tidx[d])} + (LW+1)'(window_size);
  assign issue = (state == ST_SCAN) && (addr_i < end_i);
  assign raddr = {d, addr_i[SW-1:0]};

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd.op == OP_LOAD && cmd.ds_ok) begin
      mem[{cmd.dataset, cmd.sample_index}] <= cmd.joints;
    end
    if (issue) begin
      rd <= mem[raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd_valid && cmd.op == OP_QUERY) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_SCAN;
      ST_SCAN:  if (!issue) state_next = ST_DRAIN;
      ST_DRAIN: if (!p1 && !p2) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!res_valid || res_ready) begin
          state_next = (d == TW'(NUM_TRAJ-1)) ? ST_IDLE : ST_SETUP;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sum_sq = '0;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      sum_sq = sum_sq + DW'(sq[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      sq[j] <= (2*JW+2)'($signed({qv[j][JW-1], qv[j]} - {rd[j][JW-1], rd[j]}) *
                         $signed({qv[j][JW-1], qv[j]} - {rd[j][JW-1], rd[j]}));
    end
    i2 <= i1;
    i1 <= addr_i[SW-1:0];
    if (state == ST_IDLE && cmd_valid && cmd.op == OP_QUERY) qv <= cmd.joints;
    if (state == ST_SETUP) begin
      addr_i <= LW'(tidx[d]);
      end_i <= (end_sum > (LW+1)'(tlen[d])) ? tlen[d] : end_sum[LW-1:0];
    end else if (issue) begin
      addr_i <= addr_i + LW'(1);
    end
    if (state == ST_SETUP) begin
      found <= 1'b0;
      best_dist <= '0;
      best_idx <= '0;
    end else if (p2 && (!found || sum_sq < best_dist)) begin
      found <= 1'b1;
      best_dist <= sum_sq;
      best_idx <= i2;
    end
    if (state == ST_EMIT && (!res_valid || res_ready)) begin
      res.dataset <= d;
      res.best_index <= best_idx;
      res.best_dist <= best_dist;
      res.empty <= ~found;
      res.last <= (d == TW'(NUM_TRAJ-1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      d <= '0;
      p1 <= 1'b0;
      p2 <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k < NUM_TRAJ; k++) begin
        tlen[k] <= '0;
        tidx[k] <= '0;
      end
    end else begin
      state <= state_next;
      p1 <= issue;
      p2 <= p1;
      if (state == ST_IDLE && cmd_valid) begin
        if (cmd.op == OP_LEN && cmd.ds_ok) tlen[cmd.dataset] <= cmd.sample_count;
        if (cmd.op == OP_CLEAR) begin
          for (int k = 0; k < NUM_TRAJ; k++) tidx[k] <= '0;
        end
        d <= '0;
      end
      if (state == ST_EMIT && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
        tidx[d] <= best_idx;
        d <= d + TW'(1);
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/windowed_nearest_sample_tracker.sv
// Top level of the windowed nearest-sample tracker.
// Input stream s_axis: one beat is a command (load sample, set length, query, clear).
// Output stream m_axis: a query produces eight beats, one per trajectory, in
// trajectory order; tlast marks the beat for the final trajectory.
// Configuration channel cfg: writes the window size (reset value 40).
// A non-query command is handled by the back end while it is idle after queuing.
// A query runs per trajectory through the setup, scan, drain and emit states over
// W samples, W being the clipped window length.
// The back end reads one stored sample per cycle from the single-port store;
// that port sets the rate.
// A two-entry command queue lets the sender run ahead of the search.
// Reset clears lengths and tracked indexes and sets the window size to 40;
// sample contents are undefined until loaded. When the receiver stalls, the
// result register holds its beat and the search waits before writing the next result.
`default_nettype none
module windowed_nearest_sample_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: dataset[2:0], sample_index[12:3], sample_count[23:13],
  // joint_0..joint_5 16 bits each from bit 24 to 119
  input  wire logic [119:0] s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: result_dataset[2:0], best_index[12:3], best_distance_sq[47:13]
  output logic [47:0]      m_axis_tdata,
  // tuser: window_empty[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);
  import wnst_pkg::*;

  logic [WW-1:0] window_size;
  logic cmd_valid, cmd_ready, res_valid;
  cmd_t cmd;
  res_t res;
  jvec_t joints;

  always_comb begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      joints[j] = s_axis_tdata[24 + JW*j +: JW];
    end
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) window_size <= WINDOW_RESET;
    else if (cfg_valid) window_size <= cfg_data;
  end

  wnst_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(op_t'(s_axis_tuser)), .dataset(s_axis_tdata[2:0]),
    .sample_index(s_axis_tdata[12:3]), .sample_count(s_axis_tdata[23:13]),
    .joints, .cmd_valid, .cmd_ready, .cmd
  );

  wnst_back u_back (
    .clk, .rst, .window_size, .cmd_valid, .cmd_ready, .cmd,
    .res_valid, .res_ready(m_axis_tready), .res
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.empty;
  assign m_axis_tdata = {res.best_dist, res.best_index, res.dataset};
endmodule
`default_nettype wire

FILE: rtl/wnst_checker.sv
// Port-level checker for the tracker, bound to the top level.
`default_nettype none
module wnst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'd7)))
    else $error("tlast does not match final trajectory");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:3] == 45'd0)
    else $error("empty window with nonzero index or distance");
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1)
    else $error("trajectory order broken");
endmodule

bind windowed_nearest_sample_tracker wnst_checker u_wnst_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
  .m_axis_tlast
);
`default_nettype wire
